// ===== rtl/pqu_pkg.sv =====
// shared types, register indexes and arithmetic helpers for the plane query unit
package pqu_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_ANCHOR_X = 3'd3;
    localparam logic [2:0] REG_ANCHOR_Y = 3'd4;
    localparam logic [2:0] REG_ANCHOR_Z = 3'd5;

    // request op codes
    localparam logic OP_CLOSEST = 1'b0;
    localparam logic OP_RAY     = 1'b1;

    // divider widths: dividend magnitude and divisor magnitude
    localparam int DVD_W = 63;
    localparam int DVS_W = 32;

    typedef struct packed {
        logic [2:0][15:0] n;
        logic [2:0][31:0] a;
    } t_plane;

    typedef struct packed {
        logic             op;
        logic [2:0][31:0] q;
        logic [2:0][15:0] d;
    } t_item;

    // side data that rides along with the divider
    typedef struct packed {
        logic             op;
        logic [2:0][31:0] q;
        logic [2:0][15:0] d;
        logic [2:0][31:0] cl_r;
        logic             cl_sat;
        logic             neg;
        logic             cnz;
    } t_carry;

    typedef struct packed {
        logic             hit;
        logic [31:0]      distance;
        logic [2:0][31:0] r;
        logic             saturated;
    } t_result;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] v;
    } t_clamp;

    // round a Q.14 scaled value to nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] x);
        logic signed [63:0] s;
        s = x + 64'sd8192;
        return s >>> 14;
    endfunction

    // clamp to a signed w-bit range
    function automatic t_clamp sat_clamp(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        t_clamp c;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        c.sat = 1'b0;
        c.v   = v;
        if (v > hi) begin
            c.sat = 1'b1;
            c.v   = hi;
        end else if (v < lo) begin
            c.sat = 1'b1;
            c.v   = lo;
        end
        return c;
    endfunction

endpackage

// ===== rtl/pqu_req_if.sv =====
// request channel of the plane query unit
interface pqu_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, op, query_x, query_y, query_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, op, query_x, query_y, query_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// ===== rtl/pqu_rsp_if.sv =====
// response channel of the plane query unit
interface pqu_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] distance;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               saturated;

    modport source (output valid, hit, distance, result_x, result_y, result_z, saturated,
                    input ready);
    modport sink (input valid, hit, distance, result_x, result_y, result_z, saturated,
                  output ready);
endinterface

// ===== rtl/plane_query_unit.sv =====
// top level of the plane query unit
// Answers point and ray queries against one plane held in six registers:
// a unit normal (Q2.14) and an anchor point (Q16.16), written through the
// i_cfg_we / i_cfg_idx / i_cfg_data port while no request is in flight.
// Requests come on the req channel: op 0 gives the closest point on the
// plane, op 1 casts a ray and reports hit, distance and hit point.
// Responses leave on the rsp channel, one per request, in order.
// Throughput is one request per cycle while req.ready is high. The path has
// 71 register stages: five front stages for the dot products and the
// projection, 63 stages of the radix-2 distance divider (one quotient bit
// each), and three back stages for the hit test, the hit point multiply and
// the output register.
// Results outside the COORD_WIDTH range are clamped and flagged.
// Reset (synchronous, active low) empties the pipeline and loads the
// normal (0, 1, 0) and the anchor at the origin.
// When the receiver stalls, a result waiting in the output register is
// held and one more lands in a skid entry; the pipeline then freezes and
// req.ready drops until the skid entry drains. Nothing is lost or repeated.
module plane_query_unit import pqu_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    pqu_req_if.sink     req,
    pqu_rsp_if.source   rsp
);

    t_plane           r_plane;
    t_item            w_item;
    logic             w_en;
    logic             w_f_valid, w_d_valid;
    t_carry           w_f_carry, w_d_carry;
    logic [DVD_W-1:0] w_dvd, w_quot;
    logic [DVS_W-1:0] w_dvs;
    t_result          w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.n <= {16'd0, 16'd16384, 16'd0};
            r_plane.a <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NORMAL_X: r_plane.n[0] <= i_cfg_data[15:0];
                REG_NORMAL_Y: r_plane.n[1] <= i_cfg_data[15:0];
                REG_NORMAL_Z: r_plane.n[2] <= i_cfg_data[15:0];
                REG_ANCHOR_X: r_plane.a[0] <= i_cfg_data;
                REG_ANCHOR_Y: r_plane.a[1] <= i_cfg_data;
                REG_ANCHOR_Z: r_plane.a[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request payload
    assign w_item.op   = req.op;
    assign w_item.q[0] = req.query_x;
    assign w_item.q[1] = req.query_y;
    assign w_item.q[2] = req.query_z;
    assign w_item.d[0] = req.dir_x;
    assign w_item.d[1] = req.dir_y;
    assign w_item.d[2] = req.dir_z;
    assign req.ready   = w_en;

    pqu_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (req.valid),
        .i_item  (w_item),
        .i_plane (r_plane),
        .o_valid (w_f_valid),
        .o_carry (w_f_carry),
        .o_dvd   (w_dvd),
        .o_dvs   (w_dvs)
    );

    pqu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_carry (w_f_carry),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_valid (w_d_valid),
        .o_carry (w_d_carry),
        .o_quot  (w_quot)
    );

    pqu_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .i_carry  (w_d_carry),
        .i_quot   (w_quot),
        .i_ready  (rsp.ready),
        .o_en     (w_en),
        .o_valid  (rsp.valid),
        .o_result (w_res)
    );

    // response payload
    assign rsp.hit       = w_res.hit;
    assign rsp.distance  = w_res.distance;
    assign rsp.result_x  = w_res.r[0];
    assign rsp.result_y  = w_res.r[1];
    assign rsp.result_z  = w_res.r[2];
    assign rsp.saturated = w_res.saturated;

endmodule

// ===== rtl/pqu_front.sv =====
// front stages: dot products, closest point and divider operand setup
module pqu_front import pqu_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_item              i_item,
    input  t_plane             i_plane,
    output logic               o_valid,
    output t_carry             o_carry,
    output logic [DVD_W-1:0]   o_dvd,
    output logic [DVS_W-1:0]   o_dvs
);

    logic               r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    t_item              r1_item, r2_item, r3_item, r4_item;
    logic signed [32:0] r1_l  [3];
    logic signed [31:0] r1_cp [3];
    logic signed [48:0] r2_lp [3];
    logic signed [33:0] r2_c;
    logic signed [50:0] r3_dot;
    logic signed [36:0] r3_p;
    logic signed [33:0] r3_c;
    logic signed [52:0] r4_pn [3];
    logic [DVD_W-1:0]   r4_dvd;
    logic [DVS_W-1:0]   r4_dvs;
    logic               r4_neg, r4_cnz;
    t_carry             r5_carry;
    logic [DVD_W-1:0]   r5_dvd;
    logic [DVS_W-1:0]   r5_dvs;

    logic signed [50:0] n_dot;
    logic signed [50:0] n_dot_r;
    logic signed [50:0] n_mag;
    logic signed [33:0] n_cmag;
    t_clamp             n_cl [3];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // stage 1: offsets from the anchor and direction products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            for (int i = 0; i < 3; i++) begin
                r1_l[i]  <= 33'($signed(i_item.q[i])) - 33'($signed(i_plane.a[i]));
                r1_cp[i] <= 32'($signed(i_item.d[i])) * 32'($signed(i_plane.n[i]));
            end
        end
    end

    // stage 2: offset products and the direction dot product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_item <= r1_item;
            for (int i = 0; i < 3; i++) begin
                r2_lp[i] <= 49'(r1_l[i]) * 49'($signed(i_plane.n[i]));
            end
            r2_c <= 34'(r1_cp[0]) + 34'(r1_cp[1]) + 34'(r1_cp[2]);
        end
    end

    // stage 3: offset dot product and its rounded projection
    assign n_dot   = 51'(r2_lp[0]) + 51'(r2_lp[1]) + 51'(r2_lp[2]);
    assign n_dot_r = n_dot + 51'sd8192;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_item <= r2_item;
            r3_dot  <= n_dot;
            r3_p    <= $signed(n_dot_r[50:14]);
            r3_c    <= r2_c;
        end
    end

    // stage 4: projection back along the normal, divider operands
    assign n_mag  = r3_dot[50] ? -r3_dot : r3_dot;
    assign n_cmag = r3_c[33] ? -r3_c : r3_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_item <= r3_item;
            for (int i = 0; i < 3; i++) begin
                r4_pn[i] <= 53'(r3_p) * 53'($signed(i_plane.n[i]));
            end
            r4_dvd <= {n_mag[48:0], 14'd0};
            r4_dvs <= n_cmag[31:0];
            // numerator is the negated offset dot product
            r4_neg <= ((r3_dot > 51'sd0) != r3_c[33]);
            r4_cnz <= (r3_c != 34'sd0);
        end
    end

    // stage 5: closest point with clamping
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cl[i] = sat_clamp(64'($signed(r4_item.q[i])) - rnd_q14(64'(r4_pn[i])),
                                COORD_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_carry.op     <= r4_item.op;
            r5_carry.q      <= r4_item.q;
            r5_carry.d      <= r4_item.d;
            for (int i = 0; i < 3; i++) begin
                r5_carry.cl_r[i] <= n_cl[i].v[31:0];
            end
            r5_carry.cl_sat <= n_cl[0].sat | n_cl[1].sat | n_cl[2].sat;
            r5_carry.neg    <= r4_neg;
            r5_carry.cnz    <= r4_cnz;
            r5_dvd          <= r4_dvd;
            r5_dvs          <= r4_dvs;
        end
    end

    assign o_valid = r5_valid;
    assign o_carry = r5_carry;
    assign o_dvd   = r5_dvd;
    assign o_dvs   = r5_dvs;

endmodule

// ===== rtl/pqu_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module pqu_div import pqu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_carry           i_carry,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_valid,
    output t_carry           o_carry,
    output logic [DVD_W-1:0] o_quot
);

    logic               r_valid [1:DVD_W];
    t_carry             r_carry [1:DVD_W];
    logic [DVS_W-1:0]   r_rem   [1:DVD_W];
    logic [DVD_W-1:0]   r_dq    [1:DVD_W];
    logic [DVS_W-1:0]   r_dvs   [1:DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic             s_valid;
        t_carry           s_carry;
        logic [DVS_W-1:0] s_rem;
        logic [DVD_W-1:0] s_dq;
        logic [DVS_W-1:0] s_dvs;
        logic [DVS_W:0]   w_rc;
        logic [DVS_W:0]   w_diff;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_carry = i_carry;
            assign s_rem   = '0;
            assign s_dq    = i_dvd;
            assign s_dvs   = i_dvs;
        end else begin : g_next
            assign s_valid = r_valid[k];
            assign s_carry = r_carry[k];
            assign s_rem   = r_rem[k];
            assign s_dq    = r_dq[k];
            assign s_dvs   = r_dvs[k];
        end

        // shift in the next dividend bit and try the subtract
        assign w_rc   = {s_rem, s_dq[DVD_W-1]};
        assign w_diff = w_rc - {1'b0, s_dvs};
        assign w_ge   = (w_rc >= {1'b0, s_dvs});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_carry[k+1] <= s_carry;
                r_rem[k+1]   <= w_ge ? w_diff[DVS_W-1:0] : w_rc[DVS_W-1:0];
                r_dq[k+1]    <= {s_dq[DVD_W-2:0], w_ge};
                r_dvs[k+1]   <= s_dvs;
            end
        end
    end

    assign o_valid = r_valid[DVD_W];
    assign o_carry = r_carry[DVD_W];
    assign o_quot  = r_dq[DVD_W];

endmodule

// ===== rtl/pqu_back.sv =====
// back stages: hit test, hit point, output register and skid buffer
module pqu_back import pqu_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_carry           i_carry,
    input  logic [DVD_W-1:0] i_quot,
    input  logic             i_ready,
    output logic             o_en,
    output logic             o_valid,
    output t_result          o_result
);

    localparam int PROD_W = COORD_WIDTH + 16;

    logic                          r_b1_valid, r_b2_valid;
    t_carry                        r_b1_carry, r_b2_carry;
    logic                          r_b1_hit, r_b2_hit;
    logic                          r_b1_sat, r_b2_sat;
    logic signed [COORD_WIDTH-1:0] r_b1_dist, r_b2_dist;
    logic signed [PROD_W-1:0]      r_b2_prod [3];
    logic                          r_out_valid, r_skid_valid;
    t_result                       r_out, r_skid;

    logic    w_en;
    t_clamp  n_dcl;
    t_clamp  n_hcl [3];
    t_result n_res;

    assign w_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid <= i_valid;
            r_b2_valid <= r_b1_valid;
        end
    end

    // stage 1: sign of the quotient, hit test and distance clamp
    assign n_dcl = sat_clamp(64'({1'b0, i_quot}), COORD_WIDTH);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_carry <= i_carry;
            r_b1_hit   <= i_carry.cnz && !i_carry.neg && (i_quot != '0);
            r_b1_sat   <= n_dcl.sat;
            r_b1_dist  <= n_dcl.v[COORD_WIDTH-1:0];
        end
    end

    // stage 2: distance times direction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b2_carry <= r_b1_carry;
            r_b2_hit   <= r_b1_hit;
            r_b2_sat   <= r_b1_sat;
            r_b2_dist  <= r_b1_dist;
            for (int i = 0; i < 3; i++) begin
                r_b2_prod[i] <= PROD_W'(r_b1_dist) * PROD_W'($signed(r_b1_carry.d[i]));
            end
        end
    end

    // stage 3: hit point and result selection
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_hcl[i] = sat_clamp(64'($signed(r_b2_carry.q[i])) + rnd_q14(64'(r_b2_prod[i])),
                                 COORD_WIDTH);
        end
        n_res = '0;
        if (r_b2_carry.op == OP_CLOSEST) begin
            n_res.r         = r_b2_carry.cl_r;
            n_res.saturated = r_b2_carry.cl_sat;
        end else if (r_b2_hit) begin
            n_res.hit       = 1'b1;
            n_res.distance  = 32'(64'(r_b2_dist));
            for (int i = 0; i < 3; i++) begin
                n_res.r[i] = n_hcl[i].v[31:0];
            end
            n_res.saturated = r_b2_sat | n_hcl[0].sat | n_hcl[1].sat | n_hcl[2].sat;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_b2_valid;
            end else if (r_b2_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_valid || i_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_en     = w_en;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
